// ===== design/bra_pkg.sv =====
package bra_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int FIELD_W         = 64;
    localparam int TDATA_W         = 136;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 4;
    localparam logic [FIELD_W-1:0] MAX_DEN_RESET = 64'd1000000;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_DEN = 4'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVA,
        S_DIVT,
        S_MUL,
        S_FMUL,
        S_FDIV,
        S_DONE
    } t_state;

endpackage

// ===== design/best_rational_approximation.sv =====
// flow: a denominator within the limit goes straight to the output state; otherwise each
//   euclid step runs a bit-serial divider for the partial quotient, a second division for
//   the limit test once q1 is nonzero, and a shift-add multiply, and the final choice adds
//   a shift-add multiply and one more division
// throughput: one fraction at a time, next accepted once the block is back in idle
// reset: synchronous active low, clears control and sets max_denominator to 1000000
module best_rational_approximation
    import bra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // in_negative, in_numerator, in_denominator, zero pad
    input  logic [TDATA_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_negative, out_numerator, out_denominator, zero pad
    output logic [TDATA_W-1:0]    m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    t_state r_state, n_state;

    logic [FIELD_W-1:0] r_max_den;
    logic [W-1:0] r_lim, n_lim;
    logic [W-1:0] r_den, n_den;
    logic [W-1:0] r_d, n_d;
    logic [W-1:0] r_p0, n_p0, r_q0, n_q0, r_p1, n_p1, r_q1, n_q1;
    logic [W-1:0] r_a, n_a, r_r, n_r;
    logic [W-1:0] r_dvd, n_dvd, r_dvs, n_dvs, r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0] r_acc_p, n_acc_p, r_acc_q, n_acc_q;
    logic [W-1:0] r_mc_p, n_mc_p, r_mc_q, n_mc_q, r_mplier, n_mplier;
    logic         r_neg, n_neg;
    logic [W-1:0] r_res_num, n_res_num, r_res_den, n_res_den;
    logic         r_m_valid, n_m_valid;
    logic         r_out_neg, n_out_neg;
    logic [W-1:0] r_out_num, n_out_num, r_out_den, n_out_den;

    logic [W-1:0] in_num, in_den, lim_m, lim_eff;
    logic [W:0]   rem_sh, diff;
    logic         ge;
    logic         cfg_wr;

    assign in_num  = s_tdata[W:1];
    assign in_den  = s_tdata[FIELD_W+W:FIELD_W+1];
    assign lim_m   = r_max_den[W-1:0];
    assign lim_eff = (lim_m == '0) ? W'(1) : lim_m;

    // one restoring division bit per cycle
    assign rem_sh = {r_rem, r_dvd[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = !diff[W];

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = r_max_den;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {7'd0, FIELD_W'(r_out_den), FIELD_W'(r_out_num), r_out_neg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den <= MAX_DEN_RESET;
        end else if (cfg_wr && paddr == ADDR_MAX_DEN) begin
            r_max_den <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim     <= n_lim;
        r_den     <= n_den;
        r_d       <= n_d;
        r_p0      <= n_p0;
        r_q0      <= n_q0;
        r_p1      <= n_p1;
        r_q1      <= n_q1;
        r_a       <= n_a;
        r_r       <= n_r;
        r_dvd     <= n_dvd;
        r_dvs     <= n_dvs;
        r_rem     <= n_rem;
        r_acc_p   <= n_acc_p;
        r_acc_q   <= n_acc_q;
        r_mc_p    <= n_mc_p;
        r_mc_q    <= n_mc_q;
        r_mplier  <= n_mplier;
        r_neg     <= n_neg;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_out_neg <= n_out_neg;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
    end

    always_comb begin
        n_state   = r_state;
        n_lim     = r_lim;
        n_den     = r_den;
        n_d       = r_d;
        n_p0      = r_p0;
        n_q0      = r_q0;
        n_p1      = r_p1;
        n_q1      = r_q1;
        n_a       = r_a;
        n_r       = r_r;
        n_dvd     = r_dvd;
        n_dvs     = r_dvs;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_acc_p   = r_acc_p;
        n_acc_q   = r_acc_q;
        n_mc_p    = r_mc_p;
        n_mc_q    = r_mc_q;
        n_mplier  = r_mplier;
        n_neg     = r_neg;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_m_valid = r_m_valid;
        n_out_neg = r_out_neg;
        n_out_num = r_out_num;
        n_out_den = r_out_den;

        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        // divider steps whenever its counter runs
        if (r_cnt != '0) begin
            n_rem = ge ? diff[W-1:0] : rem_sh[W-1:0];
            n_dvd = {r_dvd[W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_neg = s_tdata[0];
                    n_lim = lim_eff;
                    n_den = in_den;
                    if (in_den <= lim_eff) begin
                        n_res_num = in_num;
                        n_res_den = in_den;
                        n_state   = S_DONE;
                    end else begin
                        n_d   = in_den;
                        n_p0  = '0;
                        n_q0  = W'(1);
                        n_p1  = W'(1);
                        n_q1  = '0;
                        n_dvd = in_num;
                        n_dvs = in_den;
                        n_rem = '0;
                        n_cnt = CNT_W'(W);
                        n_state = S_DIVA;
                    end
                end
            end
            S_DIVA: begin
                if (r_cnt == '0) begin
                    n_a = r_dvd;
                    n_r = r_rem;
                    if (r_q1 == '0) begin
                        n_acc_p  = r_p0;
                        n_acc_q  = r_q0;
                        n_mc_p   = r_p1;
                        n_mc_q   = r_q1;
                        n_mplier = r_dvd;
                        n_state  = S_MUL;
                    end else begin
                        n_dvd   = r_lim - r_q0;
                        n_dvs   = r_q1;
                        n_rem   = '0;
                        n_cnt   = CNT_W'(W);
                        n_state = S_DIVT;
                    end
                end
            end
            S_DIVT: begin
                if (r_cnt == '0) begin
                    n_acc_p = r_p0;
                    n_acc_q = r_q0;
                    n_mc_p  = r_p1;
                    n_mc_q  = r_q1;
                    if (r_a > r_dvd) begin
                        n_mplier = r_dvd;
                        n_state  = S_FMUL;
                    end else begin
                        n_mplier = r_a;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL, S_FMUL: begin
                if (r_mplier != '0) begin
                    if (r_mplier[0]) begin
                        n_acc_p = r_acc_p + r_mc_p;
                        n_acc_q = r_acc_q + r_mc_q;
                    end
                    n_mc_p   = {r_mc_p[W-2:0], 1'b0};
                    n_mc_q   = {r_mc_q[W-2:0], 1'b0};
                    n_mplier = {1'b0, r_mplier[W-1:1]};
                end else if (r_state == S_MUL) begin
                    n_p0 = r_p1;
                    n_q0 = r_q1;
                    n_p1 = r_acc_p;
                    n_q1 = r_acc_q;
                    n_d  = r_r;
                    if (r_r == '0) begin
                        n_res_num = r_acc_p;
                        n_res_den = r_acc_q;
                        n_state   = S_DONE;
                    end else begin
                        n_dvd   = r_d;
                        n_dvs   = r_r;
                        n_rem   = '0;
                        n_cnt   = CNT_W'(W);
                        n_state = S_DIVA;
                    end
                end else begin
                    // semiconvergent kept in the accumulators
                    n_dvd   = {1'b0, r_den[W-1:1]};
                    n_dvs   = r_d;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(W);
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                if (r_cnt == '0) begin
                    if (r_acc_q <= r_dvd) begin
                        n_res_num = r_p1;
                        n_res_den = r_q1;
                    end else begin
                        n_res_num = r_acc_p;
                        n_res_den = r_acc_q;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_out_neg = r_neg;
                    n_out_num = r_res_num;
                    n_out_den = r_res_den;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_den_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_m_valid || m_tready)) |=> (r_out_den <= r_lim))
        else $error("result denominator above limit");

    a_divt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVT) |-> (r_dvs != '0))
        else $error("limit test divides by zero");

    a_fdiv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FDIV) |-> (r_dvs != '0))
        else $error("final comparison divides by zero");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> (r_cnt == '0))
        else $error("divider running outside a division");
`endif

endmodule

// ===== tb/best_rational_approximation_checker.sv =====
module best_rational_approximation_checker
    import bra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_words
);
    // packed from the top bit down, so neg lands in bit 0 as on the bus
    typedef struct packed {
        logic [63:0] den;
        logic [63:0] num;
        logic        neg;
    } t_frac;

    logic [63:0] den_limit;
    t_frac       approx_q[$];

    function automatic t_frac approximate(input t_frac x, input logic [63:0] limit_in);
        logic [63:0] lim, p0, q0, p1, q1, n, d, a, k, sq, np, nq, r;
        t_frac y;
        bit exact;
        lim = (limit_in == 0) ? 64'd1 : limit_in;
        p0 = 0; q0 = 1; p1 = 1; q1 = 0;
        exact = 0;
        y.neg = x.neg;
        if (x.den <= lim) begin
            y.num = x.num;
            y.den = x.den;
            return y;
        end
        n = x.num;
        d = x.den;
        forever begin
            a = n / d;
            if (q1 != 0 && a > (lim - q0) / q1) break;
            np = p0 + a * p1;
            nq = q0 + a * q1;
            p0 = p1; q0 = q1; p1 = np; q1 = nq;
            r = n - a * d;
            n = d;
            d = r;
            if (d == 0) begin
                exact = 1;
                break;
            end
        end
        if (exact) begin
            y.num = p1;
            y.den = q1;
            return y;
        end
        k = (lim - q0) / q1;
        sq = q0 + k * q1;
        if (sq <= (x.den / 2) / d) begin
            y.num = p1;
            y.den = q1;
        end else begin
            y.num = p0 + k * p1;
            y.den = sq;
        end
        return y;
    endfunction

    always @(posedge i_clk) begin
        t_frac got, want;
        if (!i_rst_n) begin
            den_limit <= MAX_DEN_RESET;
            o_errors  <= 0;
            o_words   <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_DEN)
                den_limit <= pwdata;
            if (s_tvalid && s_tready)
                approx_q.push_back(approximate(t_frac'(s_tdata[128:0]), den_limit));
            if (m_tvalid && m_tready) begin
                got = t_frac'(m_tdata[128:0]);
                o_words <= o_words + 1;
                if (approx_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = approx_q.pop_front();
                    if (got.neg !== want.neg || got.num !== want.num || got.den !== want.den) begin
                        $display("%0t: expected %0d %0d/%0d got %0d %0d/%0d", $time,
                                 want.neg, want.num, want.den, got.neg, got.num, got.den);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= approx_q.size();
        end
    end
endmodule

// ===== tb/best_rational_approximation_test.sv =====
module best_rational_approximation_test;
    import bra_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [TDATA_W-1:0] m_tdata;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic               pready;
    int                 errors, pending, words;
    int                 cycles = 0;
    int                 sent = 0;
    bit                 hold_off = 0;
    bit                 long_hold_done = 0;

    localparam int LIMIT = 20000000;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    best_rational_approximation DUT (.*);

    best_rational_approximation_checker chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_errors(errors), .o_pending(pending), .o_words(words)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("best_rational_approximation_test NOT OK");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 9) < 7)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 9) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 1) == 1);
    end

    initial begin
        repeat (20) @(posedge i_clk);
        wait (sent >= 40);
        @(posedge i_clk);
        hold_off <= 1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 0;
        long_hold_done <= 1;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rnd_bits(input int bits);
        logic [63:0] v;
        v = rnd64();
        if (bits < 64) v = v & ((64'd1 << bits) - 1);
        return v;
    endfunction

    task automatic cfg_write(input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_MAX_DEN; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send(input logic neg, input logic [63:0] num, input logic [63:0] den);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, den, num, neg};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_items(input int count, input logic [63:0] lim);
        int bits;
        logic [63:0] n, d;
        repeat (count) begin
            bits = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(4, 24);
            n = rnd_bits(bits);
            d = rnd_bits(bits);
            case ($urandom_range(0, 5))
                0: d = rnd_bits(64);
                1: n = rnd_bits(64);
                2: d = lim + 64'($urandom_range(0, 3));
                3: d = 64'($urandom_range(0, 3));
                default: ;
            endcase
            send(1'($urandom_range(0, 1)), n, d);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed at reset limit
        send(1'b0, 64'd0, 64'd0);
        send(1'b1, 64'd5, 64'd0);
        send(1'b0, 64'd0, 64'd12345678901);
        send(1'b1, 64'd355, 64'd113);
        send(1'b0, 64'd314159265358979, 64'd100000000000000);
        send(1'b1, '1, '1);
        send(1'b0, '1, 64'd1000001);
        send(1'b1, 64'd1, '1);
        send(1'b0, 64'd2000002, 64'd4000004);
        send(1'b0, 64'd1, 64'd2000001);
        send(1'b1, 64'd3000000, 64'd1000001);
        send(1'b0, 64'd1000000, 64'd1000000);
        drain();

        cfg_write(64'd0);
        send(1'b0, 64'd3, 64'd2);
        send(1'b1, 64'd5, 64'd4);
        send(1'b0, 64'd7, 64'd9);
        send(1'b0, 64'd1, 64'd4);
        drain();

        cfg_write(64'd1);
        send(1'b0, 64'd3, 64'd4);
        send(1'b1, 64'd3, 64'd2);
        drain();

        cfg_write('1);
        send(1'b0, '1, '1);
        send(1'b1, 64'd123456789, 64'hFFFF_FFFF_FFFF_FFFE);
        drain();

        cfg_write(64'd7);
        send(1'b0, 64'd314159, 64'd100000);
        send(1'b0, 64'd1, 64'd15);
        send(1'b1, 64'd8, 64'd15);
        drain();

        cfg_write(64'd1000);
        random_items(50, 64'd1000);
        drain();

        cfg_write(64'hFFFF_FFFF);
        random_items(25, 64'hFFFF_FFFF);
        drain();

        cfg_write(64'd3);
        random_items(25, 64'd3);
        drain();
        wait (long_hold_done);

        $display("covered %0d words over limits 0, 1, 3, 7, 1000, 2^32-1, 2^64-1 and reset", words);
        $display("including zero denominators, unreduced input, ties and a long output stall");
        if (errors == 0 && pending == 0)
            $display("best_rational_approximation_test OK");
        else
            $display("best_rational_approximation_test NOT OK");
        $finish;
    end
endmodule
